// ===== rtl/dtes_pkg.sv =====
// ----------------------------------------------------------------------------
// dtes_pkg
// Constants and helpers for the calendar date to epoch seconds converter.
// ----------------------------------------------------------------------------
package dtes_pkg;

   // Calendar constants.
   localparam int unsigned EpochYear     = 1970;
   localparam int unsigned CenturyBase   = 2000;
   localparam int unsigned TwoDigitLimit = 69;
   localparam int unsigned SecsPerDay    = 86400;
   localparam int unsigned SecsPerHour   = 3600;
   localparam int unsigned SecsPerMinute = 60;
   localparam int unsigned DaysPerYear   = 365;
   // Leap days counted up to the epoch year, as floor(1969 / 4).
   localparam int unsigned LeapBase      = (EpochYear - 1) / 4;

   // Field widths.
   localparam int unsigned YearWidth   = 12;
   localparam int unsigned MonthWidth  = 4;
   localparam int unsigned DayWidth    = 5;
   localparam int unsigned HourWidth   = 5;
   localparam int unsigned MinuteWidth = 6;
   localparam int unsigned SecondWidth = 6;
   localparam int unsigned ZoneWidth   = 5;
   localparam int unsigned EpochWidth  = 37;

   // Register indexes on the configuration port.
   typedef enum logic {
      CSR_ZONE_OFFSET = 1'b0
   } csr_index_type;

   // Days of the year before the first of the given month, no leap day.
   // Months beyond December count as December.
   function automatic logic [8:0] days_before_month(input logic [MonthWidth-1:0] month);
      logic [8:0] days;
      case (month)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd59;
         4'd3:    days = 9'd90;
         4'd4:    days = 9'd120;
         4'd5:    days = 9'd151;
         4'd6:    days = 9'd181;
         4'd7:    days = 9'd212;
         4'd8:    days = 9'd243;
         4'd9:    days = 9'd273;
         4'd10:   days = 9'd304;
         default: days = 9'd334;
      endcase
      return days;
   endfunction

endpackage

// ===== rtl/date_to_epoch_seconds.sv =====
// ----------------------------------------------------------------------------
// date_to_epoch_seconds
// Converts a calendar date and time into signed seconds since 1970-01-01,
// less a configured time-zone offset in hours.
// ----------------------------------------------------------------------------
// The result strobes once an accepted beat has passed all pipeline registers.
// Throughput: one beat per cycle; busy is always low, and the four-stage
// pipeline (decode, day count, scaling, final add) never stalls.
// Reset clears the stage valid bits and sets the zone offset to 11 hours.
// The receiver cannot stall, so results leave in the cycle they are ready.
module date_to_epoch_seconds
   import dtes_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // Command channel.
   input  logic                          start,
   output logic                          busy,
   input  logic [YearWidth-1:0]          req_year_in,
   input  logic [MonthWidth-1:0]         req_month_index,
   input  logic [DayWidth-1:0]           req_day_of_month,
   input  logic [HourWidth-1:0]          req_hour_in,
   input  logic [MinuteWidth-1:0]        req_minute_in,
   input  logic [SecondWidth-1:0]        req_second_in,
   // Result channel.
   output logic                          rsp_valid,
   output logic signed [EpochWidth-1:0]  rsp_epoch_seconds,
   // Configuration port.
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   // ------------------------------------------------------------------------
   // Configuration register.
   // ------------------------------------------------------------------------
   logic signed [ZoneWidth-1:0] zone_ff, zone_in;
   logic                        csr_write;
   csr_index_type               csr_index;

   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Writes to the zone register replace it; anything else keeps it.
   always_comb begin
      zone_in = zone_ff;
      if (csr_write && (csr_index == CSR_ZONE_OFFSET)) begin
         zone_in = csr_pwdata[ZoneWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= ZoneWidth'(11);
      end else begin
         zone_ff <= zone_in;
      end
   end

   // Reads return the zone offset sign-extended, zero elsewhere.
   always_comb begin
      case (csr_index)
         CSR_ZONE_OFFSET: csr_prdata = 32'(zone_ff);
         default:         csr_prdata = 32'd0;
      endcase
   end

   // The pipeline takes a beat in every cycle.
   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // ------------------------------------------------------------------------
   // Stage 1: year fix-up, month table, leap day and time-of-day pieces.
   // ------------------------------------------------------------------------
   logic [YearWidth-1:0]  year_full;
   logic                  leap_day;
   logic                  v1_ff;
   logic signed [12:0]    yoff_ff, yoff_in;
   logic [9:0]            leapq_ff, leapq_in;
   logic [8:0]            mdays_ff, mdays_in;
   logic [DayWidth-1:0]   day_ff;
   logic signed [6:0]     hz_ff, hz_in;
   logic [11:0]           ms1_ff, ms1_in;

   always_comb begin
      // Two-digit years below the limit belong to this century.
      if (req_year_in < YearWidth'(TwoDigitLimit)) begin
         year_full = req_year_in + YearWidth'(CenturyBase);
      end else begin
         year_full = req_year_in;
      end
      yoff_in  = signed'({1'b0, year_full}) - 13'sd1970;
      leapq_in = 10'((year_full - 12'd1) >> 2);
      leap_day = (req_month_index > 4'd1) && (year_full[1:0] == 2'b00);
      mdays_in = days_before_month(req_month_index) + 9'(leap_day);
      hz_in    = signed'(7'(req_hour_in)) - 7'(zone_ff);
      ms1_in   = 12'(req_minute_in) * 12'(SecsPerMinute) + 12'(req_second_in);
   end

   always_ff @(posedge clock) begin
      yoff_ff  <= yoff_in;
      leapq_ff <= leapq_in;
      mdays_ff <= mdays_in;
      day_ff   <= req_day_of_month;
      hz_ff    <= hz_in;
      ms1_ff   <= ms1_in;
   end

   // ------------------------------------------------------------------------
   // Stage 2: day count since the epoch and hour scaling.
   // ------------------------------------------------------------------------
   logic                  v2_ff;
   logic signed [20:0]    days_ff, days_in;
   logic signed [18:0]    hzs_ff, hzs_in;
   logic [11:0]           ms2_ff;

   always_comb begin
      days_in = 21'(yoff_ff) * 21'sd365
              + signed'(21'(leapq_ff)) - 21'sd492
              + signed'(21'(mdays_ff))
              + signed'(21'(day_ff)) - 21'sd1;
      hzs_in  = 19'(hz_ff) * 19'sd3600;
   end

   always_ff @(posedge clock) begin
      days_ff <= days_in;
      hzs_ff  <= hzs_in;
      ms2_ff  <= ms1_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 3: days to seconds and the time-of-day sum.
   // ------------------------------------------------------------------------
   logic                         v3_ff;
   logic signed [37:0]           dprod;
   logic signed [EpochWidth-1:0] dsec_ff;
   logic signed [19:0]           tsec_ff, tsec_in;

   always_comb begin
      dprod   = 38'(days_ff) * 38'sd86400;
      tsec_in = 20'(hzs_ff) + signed'(20'(ms2_ff));
   end

   always_ff @(posedge clock) begin
      dsec_ff <= dprod[EpochWidth-1:0];
      tsec_ff <= tsec_in;
   end

   // ------------------------------------------------------------------------
   // Stage 4: final add into the result register.
   // ------------------------------------------------------------------------
   logic                         rsp_valid_ff;
   logic signed [EpochWidth-1:0] result_ff, result_in;

   assign result_in = dsec_ff + EpochWidth'(tsec_ff);

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   // Valid bits travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_epoch_seconds = result_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // Every accepted beat shows up as a result after passing all stage registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("accepted beat did not produce a result");

   // A result never appears unless the stage-3 valid bit held a beat before it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(v3_ff))
      else $error("result strobe without a matching beat");

   // A zone register write lands with the written value.
   a_zone_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_index == CSR_ZONE_OFFSET)) |=>
      (zone_ff == $past(csr_pwdata[ZoneWidth-1:0])))
      else $error("zone offset write lost");

   // The zone register only changes through a write.
   a_zone_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_write |=> $stable(zone_ff))
      else $error("zone offset changed without a write");

endmodule

// ===== tb/epoch_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_scoreboard_pkg
// Expected-value scoreboard for the date to epoch seconds converter. It holds
// its own copy of the zone offset, turns every accepted date beat into the
// expected seconds count and compares result beats against them in order.
// ----------------------------------------------------------------------------
package epoch_scoreboard_pkg;

   class epoch_scoreboard;
      // Zone offset in hours as currently programmed into the block.
      logic signed [4:0] zone_hours;
      // Expected seconds counts, oldest first.
      logic [36:0]       seconds_q[$];
      int                errors;
      // Days in the year before the first of each month, no leap day.
      int                month_start[12];

      function new();
         zone_hours  = 5'sd11;
         errors      = 0;
         month_start = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      endfunction

      // Work out the seconds count that an accepted date beat must produce.
      function void note_date(input logic [11:0] year_in, input logic [3:0] month_in,
                              input logic [4:0] day_in, input logic [4:0] hour_in,
                              input logic [5:0] minute_in, input logic [5:0] second_in);
         longint year;
         longint days;
         longint total;
         int     month;
         year = longint'(year_in);
         // Two-digit years count from 2000.
         if (year < 69)
            year = year + 2000;
         // Year is at least 69, so the division below is a true floor. Leap days
         // before 1970 come out negative.
         days = (year - 1970) * 365 + ((year - 1) / 4 - 492);
         // Months past December count as December.
         month = (month_in > 4'd11) ? 11 : int'(month_in);
         days = days + month_start[month];
         if (month > 1 && (year % 4) == 0)
            days = days + 1;
         // Day zero and days past the month end are taken as given.
         days = days + longint'(day_in) - 1;
         total = days * 86400 + longint'(hour_in) * 3600 + longint'(minute_in) * 60
                 + longint'(second_in) - longint'(zone_hours) * 3600;
         seconds_q.push_back(total[36:0]);
      endfunction

      // Compare one result beat against the oldest expectation.
      function void check_seconds(input logic [36:0] got);
         logic [36:0] want;
         if (seconds_q.size() == 0) begin
            errors++;
            $display("%0t: result %0d arrived with no date pending", $time,
                     $signed(got));
         end else begin
            want = seconds_q.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: epoch_seconds expected %0d actual %0d", $time,
                        $signed(want), $signed(got));
            end
         end
      endfunction

      function int pending();
         return seconds_q.size();
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for date_to_epoch_seconds. Directed dates cover the year folding,
// the years before 1970, leap February, clamped months, day zero, overflowing
// days and out-of-range times; random dates follow under a range of zone
// offsets and sender gap rates. Every result beat is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
   import dtes_pkg::*;
   import epoch_scoreboard_pkg::*;

   localparam int Latency       = 4;
   localparam int WatchdogLimit = 2000;
   localparam int ItemsPerPhase = 67;
   localparam int NumPhases     = 9;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [YearWidth-1:0]         req_year_in;
   logic [MonthWidth-1:0]        req_month_index;
   logic [DayWidth-1:0]          req_day_of_month;
   logic [HourWidth-1:0]         req_hour_in;
   logic [MinuteWidth-1:0]       req_minute_in;
   logic [SecondWidth-1:0]       req_second_in;
   logic                         rsp_valid;
   logic signed [EpochWidth-1:0] rsp_epoch_seconds;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [2:0]                   csr_paddr;
   logic [31:0]                  csr_pwdata;
   logic [31:0]                  csr_prdata;
   logic                         csr_pready;

   epoch_scoreboard sb;
   int              sender_idle_pct;
   int              idle_cycles;

   date_to_epoch_seconds u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_year_in       (req_year_in),
      .req_month_index   (req_month_index),
      .req_day_of_month  (req_day_of_month),
      .req_hour_in       (req_hour_in),
      .req_minute_in     (req_minute_in),
      .req_second_in     (req_second_in),
      .rsp_valid         (rsp_valid),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // Clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Note accepted date beats and check result beats.
   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note_date(req_year_in, req_month_index, req_day_of_month, req_hour_in,
                      req_minute_in, req_second_in);
      if (!reset && rsp_valid)
         sb.check_seconds(rsp_epoch_seconds);
   end

   // Watchdog: give up after too many cycles with no beat on either side.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WatchdogLimit) begin
         $display("date_to_epoch_seconds: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one date beat after an optional random gap and hold it until taken.
   task automatic send_date(input logic [11:0] year_in, input logic [3:0] month_in,
                            input logic [4:0] day_in, input logic [4:0] hour_in,
                            input logic [5:0] minute_in, input logic [5:0] second_in);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_year_in      <= year_in;
      req_month_index  <= month_in;
      req_day_of_month <= day_in;
      req_hour_in      <= hour_in;
      req_minute_in    <= minute_in;
      req_second_in    <= second_in;
      do
         @(posedge clock);
      while (busy);
   endtask

   // Mostly calendar-valid dates over several year bands, the rest raw bits.
   task automatic send_random_date();
      logic [11:0] year_in;
      logic [3:0]  month_in;
      logic [4:0]  day_in;
      logic [4:0]  hour_in;
      logic [5:0]  minute_in;
      logic [5:0]  second_in;
      if ($urandom_range(99) < 20) begin
         year_in   = 12'($urandom);
         month_in  = 4'($urandom);
         day_in    = 5'($urandom);
         hour_in   = 5'($urandom);
         minute_in = 6'($urandom);
         second_in = 6'($urandom);
      end else begin
         case ($urandom_range(3))
            0: year_in = 12'($urandom_range(68));
            1: year_in = 12'($urandom_range(2100, 1900));
            2: year_in = 12'($urandom_range(1969, 69));
            default: year_in = 12'($urandom_range(4095));
         endcase
         month_in  = 4'($urandom_range(11));
         day_in    = 5'($urandom_range(31, 1));
         hour_in   = 5'($urandom_range(23));
         minute_in = 6'($urandom_range(59));
         second_in = 6'($urandom_range(59));
      end
      send_date(year_in, month_in, day_in, hour_in, minute_in, second_in);
   endtask

   // Stop sending and wait for the pipeline to drain.
   task automatic drain_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (Latency + 2) @(posedge clock);
   endtask

   // Program the zone offset over the configuration port; upper data bits are noise.
   task automatic write_zone(input logic signed [4:0] zone);
      logic [31:0] data;
      data        = $urandom;
      data[4:0]   = zone;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_ZONE_OFFSET, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.zone_hours = zone;
   endtask

   initial begin
      int                phase;
      int                idle_modes[3];
      logic signed [4:0] zone;
      sb               = new();
      idle_modes       = '{0, 48, 12};
      sender_idle_pct  = 0;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_year_in      <= '0;
      req_month_index  <= '0;
      req_day_of_month <= '0;
      req_hour_in      <= '0;
      req_minute_in    <= '0;
      req_second_in    <= '0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed dates under the reset zone offset, back to back.
      send_date(1970, 0, 1, 0, 0, 0);
      send_date(0, 0, 1, 0, 0, 0);
      send_date(68, 11, 31, 23, 59, 59);
      send_date(69, 0, 1, 0, 0, 0);
      send_date(70, 5, 15, 8, 0, 0);
      send_date(1969, 11, 31, 23, 59, 59);
      send_date(1968, 1, 29, 0, 0, 0);
      send_date(1968, 2, 1, 0, 0, 0);
      send_date(1972, 1, 29, 12, 30, 30);
      send_date(1972, 2, 1, 0, 0, 0);
      send_date(2038, 0, 19, 3, 14, 8);
      send_date(2100, 2, 1, 0, 0, 0);
      send_date(4095, 11, 31, 23, 59, 59);
      send_date(4095, 15, 31, 31, 63, 63);
      send_date(0, 0, 0, 0, 0, 0);
      send_date(2048, 6, 0, 0, 0, 0);
      send_date(2024, 12, 1, 0, 0, 0);
      send_date(2024, 13, 2, 0, 0, 0);
      send_date(2024, 14, 3, 0, 0, 0);
      send_date(2024, 15, 4, 0, 0, 0);
      send_date(2023, 1, 31, 0, 0, 0);
      send_date(1970, 0, 1, 31, 63, 63);
      drain_pipeline();

      // Random phases, each under its own zone offset and gap rate.
      for (phase = 0; phase < NumPhases; phase++) begin
         case (phase)
            0: zone = -5'sd12;
            1: zone = 5'sd14;
            2: zone = -5'sd16;
            3: zone = 5'sd15;
            4: zone = 5'sd0;
            default: zone = 5'($urandom_range(31));
         endcase
         write_zone(zone);
         sender_idle_pct = idle_modes[phase % 3];
         repeat (ItemsPerPhase) send_random_date();
         drain_pipeline();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("date_to_epoch_seconds: match");
      end else begin
         $display("date_to_epoch_seconds: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/dtes_pkg.sv
rtl/date_to_epoch_seconds.sv
tb/epoch_scoreboard_pkg.sv
tb/tb_top.sv
